[design/ctrv_pkg.sv]
// Shared types, constants and helper functions for the turning target motion block.
// Used by every module of the block; depends on nothing else.
package ctrv_pkg;

    // Angles are Q9.16 degrees.
    localparam logic [24:0] FULL_TURN     = 25'd23592960;
    localparam logic [24:0] HALF_TURN     = 25'd11796480;
    localparam logic [24:0] QUARTER_TURN  = 25'd5898240;
    localparam logic [24:0] THREE_QUARTER = 25'd17694720;

    // Arithmetic constants.
    localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
    localparam logic signed [33:0] DEG_TO_RAD_Q30 = 34'sd18740330;
    localparam logic signed [33:0] RAD_TO_DEG_Q14 = 34'sd938734;
    localparam logic signed [23:0] STRAIGHT_LIMIT = 24'sd65;
    localparam logic [4:0]         ROTATIONS      = 5'd18;
    localparam int                 QUO_W          = 47;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_X       = 3'd0;
    localparam logic [2:0] CFG_START_Y       = 3'd1;
    localparam logic [2:0] CFG_START_HEADING = 3'd2;
    localparam logic [2:0] CFG_SPEED         = 3'd3;
    localparam logic [2:0] CFG_TURN_RATE     = 3'd4;

    typedef logic signed [39:0] t_pos;
    typedef logic signed [47:0] t_inc;
    typedef logic signed [33:0] t_opnd;
    typedef logic signed [67:0] t_prod;

    // Result of the rotation unit.
    typedef struct packed {
        logic               done;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [25:0] z;
    } t_cordic_res;

    // Request to the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [35:0] divisor;
    } t_div_req;

    // Arctangent of 2^-i in Q.16 degrees.
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14667;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // Position plus increment, clamped to the signed 40 bit range.
    function automatic t_pos sat_add(input t_pos pos, input t_inc inc);
        logic [48:0] sum;
        t_pos        res;
        sum = {{9{pos[39]}}, pos} + {inc[47], inc};
        if (sum[48:39] == {10{sum[48]}}) begin
            res = sum[39:0];
        end else if (sum[48]) begin
            res = {1'b1, {39{1'b0}}};
        end else begin
            res = {1'b0, {39{1'b1}}};
        end
        return res;
    endfunction

endpackage

[design/ctrv_mul.sv]
// Shared signed 34 x 34 multiplier with a registered product.
// Depends on ctrv_pkg for the operand and product types.
module ctrv_mul (
    input  logic           i_clk,
    input  ctrv_pkg::t_opnd i_a,
    input  ctrv_pkg::t_opnd i_b,
    output ctrv_pkg::t_prod o_p
);
    import ctrv_pkg::*;

    t_prod r_p;

    // The product is registered: it is ready in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[design/ctrv_cordic.sv]
// Iterative CORDIC rotation unit: one shift-add rotation per cycle, 18 rotations.
// Depends on ctrv_pkg for the gain, the arctangent table and the result struct.
module ctrv_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [25:0]    i_z,
    output ctrv_pkg::t_cordic_res o_res
);
    import ctrv_pkg::*;

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [25:0] r_z;
    logic [4:0]         r_idx;
    logic               r_busy;
    logic               r_done;

    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [25:0] at;

    // Shifted terms for the current rotation.
    always_comb begin
        x_sh = r_x >>> r_idx;
        y_sh = r_y >>> r_idx;
        at   = $signed({4'b0, atan_entry(r_idx)});
    end

    // Control: counts the rotations and flags the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                r_idx <= r_idx + 5'd1;
                if (r_idx == ROTATIONS - 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: rotate towards a zero residual angle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= i_z;
        end else if (r_busy) begin
            if (!r_z[25]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + at;
            end
        end
    end

    assign o_res = '{done: r_done, x: r_x, y: r_y, z: r_z};

endmodule

[design/ctrv_div.sv]
// Restoring divider, one quotient bit per cycle over a 64 bit dividend.
// Depends on ctrv_pkg for the request struct and the quotient width.
module ctrv_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ctrv_pkg::t_div_req         i_req,
    output logic [ctrv_pkg::QUO_W-1:0] o_quo,
    output logic                       o_done
);
    import ctrv_pkg::*;

    logic [35:0] r_rem;
    logic [63:0] r_quo;
    logic [35:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [36:0] rem_sh;
    logic [37:0] diff;
    logic        ge;

    // Trial subtraction for the next quotient bit.
    always_comb begin
        rem_sh = {r_rem, r_quo[63]};
        diff   = {1'b0, rem_sh} - {2'b0, r_div};
        ge     = !diff[37];
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[35:0] : rem_sh[35:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_quo  = r_quo[QUO_W-1:0];
    assign o_done = r_done;

endmodule

[design/ctrv_target_motion_step.sv]
// Turning target motion step: a sequencer drives a shared multiplier, a CORDIC unit and a divider.
// A restart loads the configured start state; a straight step uses one 18-rotation CORDIC run; a turning
// step uses two 18-rotation CORDIC runs and two 64-bit divisions. One item at a time.
// A result waits in the output register while the next item is already accepted.
// Synchronous active-low reset clears position, heading, configuration and the sequencer.
module ctrv_target_motion_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [19:0]         i_time_step,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ctrv_pkg::t_pos      o_pos_x,
    output ctrv_pkg::t_pos      o_pos_y,
    output logic [24:0]         o_heading_now,
    output logic                o_straight_mode,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [39:0]         i_cfg_data
);
    import ctrv_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DELTA  = 10'b0000000010,
        S_WRAP   = 10'b0000000100,
        S_FOLD   = 10'b0000001000,
        S_ROT    = 10'b0000010000,
        S_RESID  = 10'b0000100000,
        S_TRAVEL = 10'b0001000000,
        S_ARC    = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    // Configuration registers.
    t_pos               r_cfg_sx;
    t_pos               r_cfg_sy;
    logic [24:0]        r_cfg_sh;
    logic [19:0]        r_cfg_v;
    logic signed [23:0] r_cfg_w;

    // Sequencer and working registers.
    t_state             r_state;
    logic [2:0]         r_step;
    logic               r_k;
    logic               r_axis;
    logic               r_flip;
    logic               r_neg;
    logic               r_straight;
    logic [19:0]        r_dt;
    logic signed [29:0] r_ang;
    logic [24:0]        r_h1;
    logic signed [33:0] r_rx;
    logic signed [33:0] r_s0;
    logic signed [33:0] r_c0;
    logic signed [33:0] r_s1;
    logic signed [33:0] r_c1;
    logic [39:0]        r_trav;
    t_prod              r_acc;
    logic [21:0]        r_ahi;

    // Target state.
    t_pos               r_px;
    t_pos               r_py;
    logic [24:0]        r_h;

    // Output register.
    logic               r_ovalid;
    t_pos               r_opx;
    t_pos               r_opy;
    logic [24:0]        r_oh;
    logic               r_ostr;

    // Shared units.
    t_opnd              mul_a;
    t_opnd              mul_b;
    t_prod              p;
    logic               cordic_start;
    logic signed [25:0] cordic_z;
    t_cordic_res        cres;
    t_div_req           dreq;
    logic [QUO_W-1:0]   quo;
    logic               div_done;

    // Derived values.
    logic               in_acc;
    logic               is_straight;
    logic [23:0]        absw;
    logic [24:0]        fold_ang;
    logic               fold_flip;
    t_prod              p_sh8;
    t_prod              p_sh38;
    t_prod              dsum;
    t_prod              dsh;
    logic signed [29:0] ang_new;
    logic signed [34:0] s_rnd;
    logic signed [34:0] c_rnd;
    logic signed [34:0] s22;
    logic signed [34:0] c22;
    logic signed [34:0] diff;
    logic signed [34:0] d_rnd;
    logic signed [34:0] d22;
    logic signed [34:0] mag;
    logic signed [33:0] nx;
    logic signed [33:0] ny;
    t_prod              tsum;
    t_prod              tinc;
    logic [63:0]        num;
    t_inc               arc_inc;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign is_straight = (r_cfg_w >= -STRAIGHT_LIMIT) && (r_cfg_w <= STRAIGHT_LIMIT);
    assign absw        = r_cfg_w[23] ? 24'(-r_cfg_w) : r_cfg_w;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sx <= '0;
            r_cfg_sy <= '0;
            r_cfg_sh <= '0;
            r_cfg_v  <= '0;
            r_cfg_w  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_X:       r_cfg_sx <= i_cfg_data;
                CFG_START_Y:       r_cfg_sy <= i_cfg_data;
                CFG_START_HEADING: r_cfg_sh <= i_cfg_data[24:0];
                CFG_SPEED:         r_cfg_v  <= i_cfg_data[19:0];
                CFG_TURN_RATE:     r_cfg_w  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Angle folding into [-90, 90] ahead of the rotation unit.
    always_comb begin
        fold_ang  = r_k ? r_h1 : r_h;
        fold_flip = 1'b0;
        if (fold_ang > QUARTER_TURN && fold_ang <= THREE_QUARTER) begin
            cordic_z  = $signed({1'b0, fold_ang}) - $signed({1'b0, HALF_TURN});
            fold_flip = 1'b1;
        end else if (fold_ang > THREE_QUARTER) begin
            cordic_z = $signed({1'b0, fold_ang}) - $signed({1'b0, FULL_TURN});
        end else begin
            cordic_z = $signed({1'b0, fold_ang});
        end
    end

    assign cordic_start = (r_state == S_FOLD);

    // Arithmetic around the shared multiplier.
    always_comb begin
        p_sh8   = p >>> 8;
        p_sh38  = p >>> 38;
        dsum    = p + 68'sd32768;
        dsh     = dsum >>> 16;
        ang_new = $signed({5'b0, r_h}) + $signed(dsh[29:0]);
        s_rnd   = {r_s0[33], r_s0} + 35'sd128;
        c_rnd   = {r_c0[33], r_c0} + 35'sd128;
        s22     = s_rnd >>> 8;
        c22     = c_rnd >>> 8;
        diff    = r_axis ? ({r_s1[33], r_s1} - {r_s0[33], r_s0})
                         : ({r_c0[33], r_c0} - {r_c1[33], r_c1});
        d_rnd   = diff + 35'sd128;
        d22     = d_rnd >>> 8;
        mag     = d22[34] ? -d22 : d22;
        nx      = cres.x - p_sh38[33:0];
        ny      = cres.y + r_rx;
        tsum    = r_acc + (p <<< 20) + 68'sd536870912;
        tinc    = tsum >>> 30;
        num     = r_acc[63:0] + {p[41:0], 22'b0};
        arc_inc = r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE: begin
                mul_a = {{10{r_cfg_w[23]}}, r_cfg_w};
                mul_b = {14'b0, i_time_step};
            end
            S_RESID: begin
                case (r_step)
                    3'd0: begin
                        mul_a = cres.x;
                        mul_b = {{8{cres.z[25]}}, cres.z};
                    end
                    3'd1: begin
                        mul_a = p_sh8[33:0];
                        mul_b = DEG_TO_RAD_Q30;
                    end
                    3'd2: begin
                        mul_a = cres.y;
                        mul_b = {{8{cres.z[25]}}, cres.z};
                    end
                    3'd3: begin
                        mul_a = p_sh8[33:0];
                        mul_b = DEG_TO_RAD_Q30;
                    end
                    default: ;
                endcase
            end
            S_TRAVEL: begin
                case (r_step)
                    3'd0: begin
                        mul_a = {14'b0, r_cfg_v};
                        mul_b = {14'b0, r_dt};
                    end
                    3'd1: begin
                        mul_a = s22[33:0];
                        mul_b = {14'b0, p[19:0]};
                    end
                    3'd2: begin
                        mul_a = s22[33:0];
                        mul_b = {14'b0, r_trav[39:20]};
                    end
                    3'd3: begin
                        mul_a = c22[33:0];
                        mul_b = {14'b0, r_trav[19:0]};
                    end
                    3'd4: begin
                        mul_a = c22[33:0];
                        mul_b = {14'b0, r_trav[39:20]};
                    end
                    default: ;
                endcase
            end
            S_ARC: begin
                case (r_step)
                    3'd0: begin
                        mul_a = {14'b0, r_cfg_v};
                        mul_b = mag[33:0];
                    end
                    3'd1: begin
                        mul_a = {12'b0, p[21:0]};
                        mul_b = RAD_TO_DEG_Q14;
                    end
                    3'd2: begin
                        mul_a = {12'b0, r_ahi};
                        mul_b = RAD_TO_DEG_Q14;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Divider request: rounded quotient of the arc numerator by the scaled turn rate.
    always_comb begin
        dreq.start    = (r_state == S_ARC) && (r_step == 3'd3);
        dreq.dividend = num + {29'b0, absw, 11'b0};
        dreq.divisor  = {absw, 12'b0};
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_k        <= 1'b0;
            r_axis     <= 1'b0;
            r_straight <= 1'b0;
            r_px       <= '0;
            r_py       <= '0;
            r_h        <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            // The output flag is set as an item completes and cleared once taken.
            if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dt   <= i_time_step;
                        r_step <= '0;
                        r_k    <= 1'b0;
                        if (!i_cmd) begin
                            r_px       <= r_cfg_sx;
                            r_py       <= r_cfg_sy;
                            r_h        <= (r_cfg_sh >= FULL_TURN) ? r_cfg_sh - FULL_TURN
                                                              : r_cfg_sh;
                            r_straight <= 1'b0;
                            r_state    <= S_DONE;
                        end else if (is_straight) begin
                            r_straight <= 1'b1;
                            r_state    <= S_FOLD;
                        end else begin
                            r_straight <= 1'b0;
                            r_state    <= S_DELTA;
                        end
                    end
                end
                S_DELTA: begin
                    r_ang   <= ang_new;
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    // Full wrap of the new heading, one turn a cycle.
                    if (r_ang[29]) begin
                        r_ang <= r_ang + $signed({5'b0, FULL_TURN});
                    end else if (r_ang >= $signed({5'b0, FULL_TURN})) begin
                        r_ang <= r_ang - $signed({5'b0, FULL_TURN});
                    end else begin
                        r_h1    <= r_ang[24:0];
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_flip  <= fold_flip;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (cres.done) begin
                        r_step  <= '0;
                        r_state <= S_RESID;
                    end
                end
                S_RESID: begin
                    if (r_step == 3'd2) begin
                        r_rx <= p_sh38[33:0];
                    end
                    if (r_step == 3'd4) begin
                        // First-order correction by the residual angle, then unfold.
                        if (!r_k) begin
                            r_s0 <= r_flip ? -ny : ny;
                            r_c0 <= r_flip ? -nx : nx;
                        end else begin
                            r_s1 <= r_flip ? -ny : ny;
                            r_c1 <= r_flip ? -nx : nx;
                        end
                        r_step <= '0;
                        if (r_straight) begin
                            r_state <= S_TRAVEL;
                        end else if (!r_k) begin
                            r_k     <= 1'b1;
                            r_state <= S_FOLD;
                        end else begin
                            r_axis  <= 1'b0;
                            r_state <= S_ARC;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_TRAVEL: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_trav <= p[39:0];
                        3'd2: r_acc  <= p;
                        3'd3: r_px   <= sat_add(r_px, tinc[47:0]);
                        3'd4: r_acc  <= p;
                        3'd5: begin
                            r_py    <= sat_add(r_py, tinc[47:0]);
                            r_state <= S_DONE;
                        end
                        default: ;
                    endcase
                end
                S_ARC: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: r_neg <= d22[34] ^ r_cfg_w[23];
                        3'd1: r_ahi <= p[43:22];
                        3'd2: r_acc <= p;
                        3'd3: r_state <= S_DIV;
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_step <= '0;
                        if (!r_axis) begin
                            r_px    <= sat_add(r_px, arc_inc);
                            r_axis  <= 1'b1;
                            r_state <= S_ARC;
                        end else begin
                            r_py    <= sat_add(r_py, arc_inc);
                            r_h     <= r_h1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output payload, loaded as the item completes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
            r_opx  <= r_px;
            r_opy  <= r_py;
            r_oh   <= r_h;
            r_ostr <= r_straight;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_pos_x         = r_opx;
    assign o_pos_y         = r_opy;
    assign o_heading_now   = r_oh;
    assign o_straight_mode = r_ostr;

    ctrv_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (p)
    );

    ctrv_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_z     (cordic_z),
        .o_res   (cres)
    );

    ctrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_quo   (quo),
        .o_done  (div_done)
    );

endmodule

[design/ctrv_checker.sv]
// Port-level checks for the turning target motion block, bound to its top level.
// Depends on ctrv_pkg for the full-turn constant.
module ctrv_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ctrv_pkg::t_pos o_pos_x,
    input ctrv_pkg::t_pos o_pos_y,
    input logic [24:0]    o_heading_now,
    input logic           o_straight_mode
);
    import ctrv_pkg::*;

    // After reset nothing is pending and the input side is open.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // An accepted item keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    // A delivered heading is always wrapped below a full turn.
    a_heading_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading_now < FULL_TURN))
        else $error("heading not wrapped");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_heading_now) && $stable(o_straight_mode))
        else $error("stalled result changed");

endmodule

bind ctrv_target_motion_step ctrv_checker u_ctrv_checker (.*);
